// File: sv/jtt_pkg.sv
// Shared types and constants for the SCARA transposed-Jacobian torque block.
// Holds the trig lane record, per-cell series coefficients and field widths.
// No dependencies.
package jtt_pkg;

    localparam int ANGLE_W   = 16;
    localparam int FORCE_W   = 32;
    localparam int LEN_W     = 16;
    localparam int POW_W     = 30;
    localparam int ACC_W     = 32;
    localparam int TRIG_W    = 32;
    localparam int CELL_COUNT = 5;
    localparam int TRIG_LAT  = 4 + 2 * CELL_COUNT + 1;
    localparam int PIPE_LAT  = TRIG_LAT + 4;

    localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
    localparam logic [ACC_W-1:0] ONE_Q30 = 32'h4000_0000;

    localparam logic [7:0] REG_ARM1 = 8'd0;
    localparam logic [7:0] REG_ARM2 = 8'd1;

    typedef struct packed {
        logic [POW_W-1:0] ps;
        logic [POW_W-1:0] pc;
        logic [POW_W-1:0] x2;
        logic [ACC_W-1:0] s_acc;
        logic [ACC_W-1:0] c_acc;
        logic [1:0]       quad;
        logic             swap;
    } lane_t;

    typedef struct packed {
        logic        s_en;
        logic        s_add;
        logic [21:0] s_div;
        logic [30:0] s_recip;
        logic [5:0]  s_shift;
        logic        c_add;
        logic [21:0] c_div;
        logic [30:0] c_recip;
        logic [5:0]  c_shift;
    } coef_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0] fx;
        logic signed [FORCE_W-1:0] fy;
        logic signed [FORCE_W-1:0] fz;
        logic signed [FORCE_W-1:0] mz;
    } force_t;

    localparam logic [30:0] RCP_6       = 31'((64'd1 << 33) / 64'd6);
    localparam logic [30:0] RCP_120     = 31'((64'd1 << 37) / 64'd120);
    localparam logic [30:0] RCP_5040    = 31'((64'd1 << 43) / 64'd5040);
    localparam logic [30:0] RCP_362880  = 31'((64'd1 << 49) / 64'd362880);
    localparam logic [30:0] RCP_2       = 31'((64'd1 << 31) / 64'd2);
    localparam logic [30:0] RCP_24      = 31'((64'd1 << 35) / 64'd24);
    localparam logic [30:0] RCP_720     = 31'((64'd1 << 40) / 64'd720);
    localparam logic [30:0] RCP_40320   = 31'((64'd1 << 46) / 64'd40320);
    localparam logic [30:0] RCP_3628800 = 31'((64'd1 << 52) / 64'd3628800);
    localparam logic [30:0] RCP_1       = 31'h4000_0000;

    // cell k divides sine x^(2k+3) (not last cell) and cosine x^(2k+2)
    function automatic coef_t cell_coef(input logic [2:0] k);
        coef_t c;
        c = '0;
        case (k)
            3'd0: c = '{1'b1, 1'b0, 22'd6, RCP_6, 6'd33,
                        1'b0, 22'd2, RCP_2, 6'd31};
            3'd1: c = '{1'b1, 1'b1, 22'd120, RCP_120, 6'd37,
                        1'b1, 22'd24, RCP_24, 6'd35};
            3'd2: c = '{1'b1, 1'b0, 22'd5040, RCP_5040, 6'd43,
                        1'b0, 22'd720, RCP_720, 6'd40};
            3'd3: c = '{1'b1, 1'b1, 22'd362880, RCP_362880, 6'd49,
                        1'b1, 22'd40320, RCP_40320, 6'd46};
            default: c = '{1'b0, 1'b1, 22'd1, RCP_1, 6'd30,
                           1'b0, 22'd3628800, RCP_3628800, 6'd52};
        endcase
        return c;
    endfunction

endpackage

// File: sv/jtt_cell.sv
// One series cell: divides the current sine/cosine powers by their factorials,
// accumulates the terms and advances both powers by x^2. Two register stages.
// Depends on jtt_pkg.
module jtt_cell (
    input  logic           clk,
    input  logic           ce,
    input  jtt_pkg::coef_t coef,
    input  jtt_pkg::lane_t lane_in,
    output jtt_pkg::lane_t lane_out
);
    import jtt_pkg::*;

    lane_t            mid_reg;
    logic [POW_W-1:0] ps_nx_reg, pc_nx_reg;
    logic [POW_W-1:0] qs0_reg, qc0_reg;

    logic [60:0]      prod_s, prod_c;
    logic [59:0]      pw_s, pw_c;
    logic [51:0]      qd_s, qd_c;
    logic [POW_W-1:0] rem_s, rem_c, qs, qc;
    logic [ACC_W-1:0] term_s, term_c;
    lane_t            lane_next;

    always_comb
    begin
        prod_s = 61'(lane_in.ps) * 61'(coef.s_recip);
        prod_c = 61'(lane_in.pc) * 61'(coef.c_recip);
        pw_s   = 60'(lane_in.ps) * 60'(lane_in.x2);
        pw_c   = 60'(lane_in.pc) * 60'(lane_in.x2);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mid_reg   <= lane_in;
            qs0_reg   <= POW_W'(prod_s >> coef.s_shift);
            qc0_reg   <= POW_W'(prod_c >> coef.c_shift);
            ps_nx_reg <= pw_s[59:30];
            pc_nx_reg <= pw_c[59:30];
        end
    end

    always_comb
    begin
        qd_s   = 52'(qs0_reg) * 52'(coef.s_div);
        qd_c   = 52'(qc0_reg) * 52'(coef.c_div);
        rem_s  = mid_reg.ps - qd_s[POW_W-1:0];
        rem_c  = mid_reg.pc - qd_c[POW_W-1:0];
        qs     = qs0_reg + POW_W'(rem_s >= POW_W'(coef.s_div));
        qc     = qc0_reg + POW_W'(rem_c >= POW_W'(coef.c_div));
        term_s = coef.s_en ? {2'b00, qs} : '0;
        term_c = {2'b00, qc};
        lane_next       = mid_reg;
        lane_next.ps    = ps_nx_reg;
        lane_next.pc    = pc_nx_reg;
        lane_next.s_acc = coef.s_add ? mid_reg.s_acc + term_s : mid_reg.s_acc - term_s;
        lane_next.c_acc = coef.c_add ? mid_reg.c_acc + term_c : mid_reg.c_acc - term_c;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            lane_out <= lane_next;
        end
    end

endmodule

// File: sv/jtt_trig.sv
// Pipelined sine/cosine of a 16-bit binary angle, Q30 results.
// Octant fold, argument scaling, then a chain of jtt_cell series cells. Uses jtt_pkg.
module jtt_trig (
    input  logic                              clk,
    input  logic                              ce,
    input  logic [jtt_pkg::ANGLE_W-1:0]       angle,
    output logic signed [jtt_pkg::TRIG_W-1:0] sin_q30,
    output logic signed [jtt_pkg::TRIG_W-1:0] cos_q30
);
    import jtt_pkg::*;

    logic [POW_W-1:0] r, rf_next;
    logic             swap_next;
    logic [POW_W-1:0] rf_reg, xa_reg, xb_reg, x2b_reg;
    logic [1:0]       quad_a_reg, quad_b_reg, quad_c_reg;
    logic             swap_a_reg, swap_b_reg, swap_c_reg;
    logic [60:0]      prod_x;
    logic [59:0]      prod_x2, prod_x3;
    lane_t            chain [0:CELL_COUNT];
    lane_t            head;
    logic signed [TRIG_W-1:0] s0, c0, sin_next, cos_next;

    always_comb
    begin
        r = {angle[ANGLE_W-3:0], 16'b0};
        swap_next = (r > 30'h2000_0000);
        rf_next   = swap_next ? POW_W'(31'h4000_0000 - {1'b0, r}) : r;
        prod_x    = 61'(rf_reg) * 61'(PI_HALF_Q30);
        prod_x2   = 60'(xa_reg) * 60'(xa_reg);
        prod_x3   = 60'(x2b_reg) * 60'(xb_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rf_reg     <= rf_next;
            quad_a_reg <= angle[ANGLE_W-1:ANGLE_W-2];
            swap_a_reg <= swap_next;
            xa_reg     <= prod_x[59:30];
            quad_b_reg <= quad_a_reg;
            swap_b_reg <= swap_a_reg;
            xb_reg     <= xa_reg;
            x2b_reg    <= prod_x2[59:30];
            quad_c_reg <= quad_b_reg;
            swap_c_reg <= swap_b_reg;
            head       <= '{ps: prod_x3[59:30], pc: x2b_reg, x2: x2b_reg,
                            s_acc: {2'b00, xb_reg}, c_acc: ONE_Q30,
                            quad: quad_c_reg, swap: swap_c_reg};
        end
    end

    assign chain[0] = head;

    for (genvar k = 0; k < CELL_COUNT; k++)
    begin : g_cell
        jtt_cell u_cell (
            .clk      (clk),
            .ce       (ce),
            .coef     (cell_coef(3'(k))),
            .lane_in  (chain[k]),
            .lane_out (chain[k+1])
        );
    end

    always_comb
    begin
        s0 = chain[CELL_COUNT].swap ? $signed(chain[CELL_COUNT].c_acc)
                                    : $signed(chain[CELL_COUNT].s_acc);
        c0 = chain[CELL_COUNT].swap ? $signed(chain[CELL_COUNT].s_acc)
                                    : $signed(chain[CELL_COUNT].c_acc);
        case (chain[CELL_COUNT].quad)
            2'd0:    begin sin_next = s0;  cos_next = c0;  end
            2'd1:    begin sin_next = c0;  cos_next = -s0; end
            2'd2:    begin sin_next = -s0; cos_next = -c0; end
            default: begin sin_next = -c0; cos_next = s0;  end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sin_q30 <= sin_next;
            cos_q30 <= cos_next;
        end
    end

endmodule

// File: sv/scara_jacobian_transpose_torque.sv
// Top level: joint torques of a two-link planar arm from a Cartesian force.
// Two jtt_trig lanes, then coefficient, product and sum stages. Uses jtt_pkg.
//
// channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | angles, forces, moment
// m       | out | m_tvalid/m_tready  | torques, lift force, wrist torque
// cfg     | in  | cfg_valid/cfg_ready| link length writes
//
// One item per cycle unless the output stalls. The trig lanes hold four front
// stages, two per series cell and one output stage; four torque stages follow.
// Every stage advances together; a stalled output holds the whole pipe.
// Reset clears the valid pipe and both link lengths; cfg_ready stays high.
module scara_jacobian_transpose_torque #(
    parameter int ANGLE_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // shoulder_angle, elbow_angle, force_x, force_y, force_z, moment_z
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // shoulder_torque, elbow_torque, lift_force, wrist_torque
    output logic [127:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import jtt_pkg::*;

    localparam int KEEP_SH = (ANGLE_BITS >= ANGLE_W) ? 0 : ANGLE_W - ANGLE_BITS;
    localparam logic [ANGLE_W-1:0] ANGLE_KEEP = ANGLE_W'({ANGLE_W{1'b1}} << KEEP_SH);

    logic [LEN_W-1:0]    arm1_reg, arm2_reg;
    logic [PIPE_LAT-1:0] valid_reg;
    logic                ce;
    logic [ANGLE_W-1:0]  a1, a12;
    force_t              frc_in;
    force_t              frc_reg [0:PIPE_LAT-2];

    logic signed [TRIG_W-1:0] s1, c1, s12, c12;
    logic signed [LEN_W:0]    l1s, l2s;
    logic signed [48:0]       ls1_reg, ls12_reg, lc1_reg, lc12_reg;
    logic signed [49:0]       nx1, py1, nx2, py2;
    logic signed [29:0]       kx1_reg, ky1_reg, kx2_reg, ky2_reg;
    logic signed [61:0]       px1_reg, py1_reg, px2_reg, py2_reg;
    logic signed [63:0]       t1, t2, m40;
    logic signed [FORCE_W-1:0] tq1_reg, tq2_reg, lift_reg, wrist_reg;

    localparam logic signed [49:0] RND20 = 50'sd524288;
    localparam logic signed [63:0] RND24 = 64'sd8388608;
    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    assign ce        = !valid_reg[PIPE_LAT-1] || m_tready;
    assign s_tready  = ce;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = valid_reg[PIPE_LAT-1];
    assign m_tdata   = {wrist_reg, lift_reg, tq2_reg, tq1_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            arm1_reg  <= '0;
            arm2_reg  <= '0;
        end
        else
        begin
            if (ce)
            begin
                valid_reg <= {valid_reg[PIPE_LAT-2:0], s_tvalid};
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_ARM1: arm1_reg <= cfg_data;
                    REG_ARM2: arm2_reg <= cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    assign a1  = s_tdata[15:0] & ANGLE_KEEP;
    assign a12 = (s_tdata[15:0] + s_tdata[31:16]) & ANGLE_KEEP;
    assign frc_in = '{fx: s_tdata[63:32], fy: s_tdata[95:64],
                      fz: s_tdata[127:96], mz: s_tdata[159:128]};

    jtt_trig u_trig1 (.clk(clk), .ce(ce), .angle(a1),  .sin_q30(s1),  .cos_q30(c1));
    jtt_trig u_trig12 (.clk(clk), .ce(ce), .angle(a12), .sin_q30(s12), .cos_q30(c12));

    assign l1s = $signed({1'b0, arm1_reg});
    assign l2s = $signed({1'b0, arm2_reg});

    always_comb
    begin
        nx1 = -(50'(ls1_reg) + 50'(ls12_reg));
        py1 = 50'(lc1_reg) + 50'(lc12_reg);
        nx2 = -50'(ls12_reg);
        py2 = 50'(lc12_reg);
        m40 = 64'(frc_reg[PIPE_LAT-2].mz) <<< 24;
        t1  = (64'(px1_reg) + 64'(py1_reg) + m40 + RND24) >>> 24;
        t2  = (64'(px2_reg) + 64'(py2_reg) + m40 + RND24) >>> 24;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            frc_reg[0] <= frc_in;
            for (int i = 1; i < PIPE_LAT - 1; i++)
            begin
                frc_reg[i] <= frc_reg[i-1];
            end
            ls1_reg  <= 49'(l1s) * 49'(s1);
            ls12_reg <= 49'(l2s) * 49'(s12);
            lc1_reg  <= 49'(l1s) * 49'(c1);
            lc12_reg <= 49'(l2s) * 49'(c12);
            kx1_reg  <= 30'((nx1 + RND20) >>> 20);
            ky1_reg  <= 30'((py1 + RND20) >>> 20);
            kx2_reg  <= 30'((nx2 + RND20) >>> 20);
            ky2_reg  <= 30'((py2 + RND20) >>> 20);
            px1_reg  <= 62'(kx1_reg) * 62'(frc_reg[PIPE_LAT-3].fx);
            py1_reg  <= 62'(ky1_reg) * 62'(frc_reg[PIPE_LAT-3].fy);
            px2_reg  <= 62'(kx2_reg) * 62'(frc_reg[PIPE_LAT-3].fx);
            py2_reg  <= 62'(ky2_reg) * 62'(frc_reg[PIPE_LAT-3].fy);
            tq1_reg  <= (t1 > SAT_HI) ? 32'sh7FFF_FFFF :
                        (t1 < SAT_LO) ? 32'sh8000_0000 : 32'(t1);
            tq2_reg  <= (t2 > SAT_HI) ? 32'sh7FFF_FFFF :
                        (t2 < SAT_LO) ? 32'sh8000_0000 : 32'(t2);
            lift_reg  <= frc_reg[PIPE_LAT-2].fz;
            wrist_reg <= frc_reg[PIPE_LAT-2].mz;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(valid_reg[PIPE_LAT-2]))
        else $error("output item with no item behind it");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

endmodule
